// ----- sv/closest_point_on_triangle_core_assert.svh -----
// assertion macros shared by the closest point core
`ifndef CLOSEST_POINT_ON_TRIANGLE_CORE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CPT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cpt_pkg.sv -----
// shared constants and types of the closest point core
`default_nettype none

package cpt_pkg;

    // limb width and latency of the pipelined multiplier
    localparam int MUL_LIMB = 32;
    localparam int MUL_LAT  = 3;

    // feature of the triangle that the query point projects onto
    typedef enum logic [2:0] {
        RGN_A,
        RGN_B,
        RGN_AB,
        RGN_C,
        RGN_AC,
        RGN_BC,
        RGN_IN
    } region_t;

endpackage

`default_nettype wire

// ----- sv/closest_point_on_triangle_core.sv -----
// closest point on a triangle to a query point, fully pipelined
//
// s_tdata carries one query: point P, then vertices A, B and C, each as
// x, y, z signed fixed point coordinates of COORD_BITS bits (any Q format,
// the result does not depend on it). m_tdata returns the nearest point of
// the triangle as x, y, z, saturated to the coordinate range.
// The point is classified into a vertex, edge or interior region from six
// dot products and three cross terms, all exact, then projected with one
// floor division per coordinate.
// The restoring divider takes COORD_BITS + 1 stages and the three multiplier
// banks three stages each. A new word is taken every cycle unless a finished
// word is held at the output.
// Reset clears only the valid bits of the pipeline; no words are in flight
// afterwards. While m_tvalid is high and m_tready low the whole pipeline
// holds and s_tready is low; nothing is dropped or repeated.
`default_nettype none

`include "closest_point_on_triangle_core_assert.svh"

module closest_point_on_triangle_core #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  wire logic [((12*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // near_x, near_y, near_z
    output logic [((3*COORD_BITS+7)/8)*8-1:0]          m_tdata
);
    import cpt_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int E        = C + 1;
    localparam int DW       = 2 * C + 4;
    localparam int VW       = 4 * C + 9;
    localparam int DENW     = VW + 2;
    localparam int NW       = VW + E + 1;
    localparam int LAT      = 3 * MUL_LAT + C + 8;
    localparam int GEO_DLY  = 2 * MUL_LAT + 2;
    localparam int DOT_DLY  = MUL_LAT + 1;
    localparam int DEN_DLY  = MUL_LAT + 1;
    localparam int BASE_DLY = MUL_LAT + C + 3;
    localparam int CLS_IDX  = 2 * MUL_LAT + 3;
    localparam int GEO_W    = 9 * C + 9 * E;
    localparam int BASE_W   = 3 * C + 1;

    logic           en;
    logic [LAT-1:0] vld_reg;

    // stage 1: edge and offset vectors
    logic signed [C-1:0] in_p [3];
    logic signed [C-1:0] in_a [3];
    logic signed [C-1:0] in_b [3];
    logic signed [C-1:0] in_c [3];
    logic signed [E-1:0] ab_reg [3];
    logic signed [E-1:0] ac_reg [3];
    logic signed [E-1:0] bc_reg [3];
    logic signed [E-1:0] ap_reg [3];
    logic signed [E-1:0] bp_reg [3];
    logic signed [E-1:0] cp_reg [3];
    logic signed [C-1:0] a_reg [3];
    logic signed [C-1:0] b_reg [3];
    logic signed [C-1:0] c_reg [3];

    logic [GEO_W-1:0] geo_bus;
    logic [GEO_W-1:0] geo_dly_reg [GEO_DLY];

    // dot products d1..d6
    logic signed [2*E-1:0] dprod [6][3];
    logic signed [DW-1:0]  dot_reg [6];
    logic [6*DW-1:0]       dot_bus;
    logic [6*DW-1:0]       dot_dly_reg [DOT_DLY];

    // cross terms
    logic signed [2*DW-1:0] xprod [6];
    logic signed [VW-1:0]   va_reg;
    logic signed [VW-1:0]   vb_reg;
    logic signed [VW-1:0]   vc_reg;

    // classification
    logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [C-1:0]  ga [3];
    logic signed [C-1:0]  gb [3];
    logic signed [C-1:0]  gc [3];
    logic signed [E-1:0]  gab [3];
    logic signed [E-1:0]  gac [3];
    logic signed [E-1:0]  gbc [3];
    region_t              rgn;
    logic                 is_a, is_b, is_ab, is_c, is_ac, is_bc;
    logic signed [DENW-1:0] w_bc;

    logic signed [C-1:0]    base_next [3];
    logic signed [E-1:0]    e1_next [3];
    logic signed [E-1:0]    e2_next [3];
    logic signed [VW-1:0]   s_next;
    logic signed [VW-1:0]   t_next;
    logic signed [DENW-1:0] den_next;
    logic                   vert_next;

    logic signed [C-1:0]    base_reg [3];
    logic signed [E-1:0]    e1_reg [3];
    logic signed [E-1:0]    e2_reg [3];
    logic signed [VW-1:0]   s_reg;
    logic signed [VW-1:0]   t_reg;
    logic signed [DENW-1:0] den_reg;
    logic                   use_base_reg;

    logic [DENW-1:0]   den_dly_reg [DEN_DLY];
    logic [BASE_W-1:0] base_bus;
    logic [BASE_W-1:0] base_dly_reg [BASE_DLY];

    // numerators and divider operands
    logic signed [VW+E-1:0] npa [3];
    logic signed [VW+E-1:0] npb [3];
    logic signed [NW-1:0]   num_reg [3];
    logic [NW-1:0]          magn_reg [3];
    logic                   negq_reg [3];
    logic [DENW-1:0]        magd_reg;
    logic signed [DENW-1:0] den_al;

    logic [C-1:0] quo [3];
    logic         rnz [3];
    logic         qneg [3];
    logic         qovf [3];

    // output stage
    logic [BASE_W-1:0]     base_out;
    logic [C:0]            magq [3];
    logic signed [C+1:0]   qpos [3];
    logic signed [C+1:0]   qval [3];
    logic signed [C+2:0]   sum [3];
    logic [C-1:0]          near_next [3];
    logic [C-1:0]          near_reg [3];

    // whole pipeline advances unless a finished word is held at the output
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_p[k] = s_tdata[k*C +: C];
            in_a[k] = s_tdata[(3+k)*C +: C];
            in_b[k] = s_tdata[(6+k)*C +: C];
            in_c[k] = s_tdata[(9+k)*C +: C];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ab_reg[k] <= E'(in_b[k]) - E'(in_a[k]);
                ac_reg[k] <= E'(in_c[k]) - E'(in_a[k]);
                bc_reg[k] <= E'(in_c[k]) - E'(in_b[k]);
                ap_reg[k] <= E'(in_p[k]) - E'(in_a[k]);
                bp_reg[k] <= E'(in_p[k]) - E'(in_b[k]);
                cp_reg[k] <= E'(in_p[k]) - E'(in_c[k]);
                a_reg[k]  <= in_a[k];
                b_reg[k]  <= in_b[k];
                c_reg[k]  <= in_c[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geo_bus[k*C +: C]           = a_reg[k];
            geo_bus[(3+k)*C +: C]       = b_reg[k];
            geo_bus[(6+k)*C +: C]       = c_reg[k];
            geo_bus[9*C + k*E +: E]     = ab_reg[k];
            geo_bus[9*C + (3+k)*E +: E] = ac_reg[k];
            geo_bus[9*C + (6+k)*E +: E] = bc_reg[k];
        end
    end

    // order: d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
    for (genvar gm = 0; gm < 6; gm++)
    begin : g_dot
        for (genvar gk = 0; gk < 3; gk++)
        begin : g_axis
            cpt_mul #(.AW(E), .BW(E)) u_mul (
                .clk (clk),
                .en  (en),
                .a   ((gm % 2 == 0) ? ab_reg[gk] : ac_reg[gk]),
                .b   ((gm / 2 == 0) ? ap_reg[gk] : ((gm / 2 == 1) ? bp_reg[gk] : cp_reg[gk])),
                .p   (dprod[gm][gk])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < 6; m++)
                dot_reg[m] <= DW'(dprod[m][0]) + DW'(dprod[m][1]) + DW'(dprod[m][2]);
        end
    end

    // vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
    cpt_mul #(.AW(DW), .BW(DW)) u_x0 (.clk(clk), .en(en), .a(dot_reg[0]), .b(dot_reg[3]),
                                      .p(xprod[0]));
    cpt_mul #(.AW(DW), .BW(DW)) u_x1 (.clk(clk), .en(en), .a(dot_reg[2]), .b(dot_reg[1]),
                                      .p(xprod[1]));
    cpt_mul #(.AW(DW), .BW(DW)) u_x2 (.clk(clk), .en(en), .a(dot_reg[4]), .b(dot_reg[1]),
                                      .p(xprod[2]));
    cpt_mul #(.AW(DW), .BW(DW)) u_x3 (.clk(clk), .en(en), .a(dot_reg[0]), .b(dot_reg[5]),
                                      .p(xprod[3]));
    cpt_mul #(.AW(DW), .BW(DW)) u_x4 (.clk(clk), .en(en), .a(dot_reg[2]), .b(dot_reg[5]),
                                      .p(xprod[4]));
    cpt_mul #(.AW(DW), .BW(DW)) u_x5 (.clk(clk), .en(en), .a(dot_reg[4]), .b(dot_reg[3]),
                                      .p(xprod[5]));

    always_comb
    begin
        for (int m = 0; m < 6; m++)
            dot_bus[m*DW +: DW] = dot_reg[m];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vc_reg <= VW'(xprod[0]) - VW'(xprod[1]);
            vb_reg <= VW'(xprod[2]) - VW'(xprod[3]);
            va_reg <= VW'(xprod[4]) - VW'(xprod[5]);
            geo_dly_reg[0] <= geo_bus;
            for (int i = 1; i < GEO_DLY; i++)
                geo_dly_reg[i] <= geo_dly_reg[i-1];
            dot_dly_reg[0] <= dot_bus;
            for (int i = 1; i < DOT_DLY; i++)
                dot_dly_reg[i] <= dot_dly_reg[i-1];
        end
    end

    // region test, in priority order
    always_comb
    begin
        d1 = dot_dly_reg[DOT_DLY-1][0*DW +: DW];
        d2 = dot_dly_reg[DOT_DLY-1][1*DW +: DW];
        d3 = dot_dly_reg[DOT_DLY-1][2*DW +: DW];
        d4 = dot_dly_reg[DOT_DLY-1][3*DW +: DW];
        d5 = dot_dly_reg[DOT_DLY-1][4*DW +: DW];
        d6 = dot_dly_reg[DOT_DLY-1][5*DW +: DW];
        for (int k = 0; k < 3; k++)
        begin
            ga[k]  = geo_dly_reg[GEO_DLY-1][k*C +: C];
            gb[k]  = geo_dly_reg[GEO_DLY-1][(3+k)*C +: C];
            gc[k]  = geo_dly_reg[GEO_DLY-1][(6+k)*C +: C];
            gab[k] = geo_dly_reg[GEO_DLY-1][9*C + k*E +: E];
            gac[k] = geo_dly_reg[GEO_DLY-1][9*C + (3+k)*E +: E];
            gbc[k] = geo_dly_reg[GEO_DLY-1][9*C + (6+k)*E +: E];
        end

        is_a  = (d1 <= 0) && (d2 <= 0);
        is_b  = (d3 >= 0) && (d4 <= d3);
        is_ab = (vc_reg <= 0) && (d1 >= 0) && (d3 <= 0);
        is_c  = (d6 >= 0) && (d5 <= d6);
        is_ac = (vb_reg <= 0) && (d2 >= 0) && (d6 <= 0);
        is_bc = (va_reg <= 0) && (d4 >= d3) && (d5 >= d6);

        if (is_a)
            rgn = RGN_A;
        else if (is_b)
            rgn = RGN_B;
        else if (is_ab)
            rgn = RGN_AB;
        else if (is_c)
            rgn = RGN_C;
        else if (is_ac)
            rgn = RGN_AC;
        else if (is_bc)
            rgn = RGN_BC;
        else
            rgn = RGN_IN;

        w_bc      = DENW'(d4) - DENW'(d3);
        s_next    = '0;
        t_next    = '0;
        den_next  = '0;
        vert_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            base_next[k] = ga[k];
            e1_next[k]   = gab[k];
            e2_next[k]   = gac[k];
        end

        case (rgn)
            RGN_A:
            begin
                vert_next = 1'b1;
            end
            RGN_B:
            begin
                vert_next = 1'b1;
                for (int k = 0; k < 3; k++)
                    base_next[k] = gb[k];
            end
            RGN_C:
            begin
                vert_next = 1'b1;
                for (int k = 0; k < 3; k++)
                    base_next[k] = gc[k];
            end
            RGN_AB:
            begin
                s_next   = VW'(d1);
                den_next = DENW'(d1) - DENW'(d3);
            end
            RGN_AC:
            begin
                s_next   = VW'(d2);
                den_next = DENW'(d2) - DENW'(d6);
                for (int k = 0; k < 3; k++)
                    e1_next[k] = gac[k];
            end
            RGN_BC:
            begin
                s_next   = VW'(d4) - VW'(d3);
                den_next = w_bc + DENW'(d5) - DENW'(d6);
                for (int k = 0; k < 3; k++)
                begin
                    base_next[k] = gb[k];
                    e1_next[k]   = gbc[k];
                end
            end
            RGN_IN:
            begin
                s_next   = vb_reg;
                t_next   = vc_reg;
                den_next = DENW'(va_reg) + DENW'(vb_reg) + DENW'(vc_reg);
            end
            default:
            begin
                vert_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                base_reg[k] <= base_next[k];
                e1_reg[k]   <= e1_next[k];
                e2_reg[k]   <= e2_next[k];
            end
            s_reg        <= s_next;
            t_reg        <= t_next;
            den_reg      <= den_next;
            // a zero divisor falls back to the starting vertex
            use_base_reg <= vert_next || (den_next == '0);
        end
    end

    for (genvar gk = 0; gk < 3; gk++)
    begin : g_num
        cpt_mul #(.AW(VW), .BW(E)) u_na (.clk(clk), .en(en), .a(s_reg), .b(e1_reg[gk]),
                                         .p(npa[gk]));
        cpt_mul #(.AW(VW), .BW(E)) u_nb (.clk(clk), .en(en), .a(t_reg), .b(e2_reg[gk]),
                                         .p(npb[gk]));
    end

    always_comb
    begin
        base_bus = {use_base_reg, base_reg[2], base_reg[1], base_reg[0]};
        den_al   = den_dly_reg[DEN_DLY-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_dly_reg[0] <= den_reg;
            for (int i = 1; i < DEN_DLY; i++)
                den_dly_reg[i] <= den_dly_reg[i-1];
            base_dly_reg[0] <= base_bus;
            for (int i = 1; i < BASE_DLY; i++)
                base_dly_reg[i] <= base_dly_reg[i-1];
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k]  <= NW'(npa[k]) + NW'(npb[k]);
                // divide magnitudes, sign of the quotient kept apart
                magn_reg[k] <= num_reg[k][NW-1] ? NW'(-num_reg[k]) : NW'(num_reg[k]);
                negq_reg[k] <= num_reg[k][NW-1] ^ den_al[DENW-1];
            end
            magd_reg <= den_al[DENW-1] ? DENW'(-den_al) : DENW'(den_al);
        end
    end

    for (genvar gk = 0; gk < 3; gk++)
    begin : g_div
        cpt_div #(.NW(NW), .DW(DENW), .QW(C)) u_div (
            .clk    (clk),
            .en     (en),
            .num    (magn_reg[gk]),
            .den    (magd_reg),
            .neg_in (negq_reg[gk]),
            .quo    (quo[gk]),
            .rem_nz (rnz[gk]),
            .neg    (qneg[gk]),
            .ovf    (qovf[gk])
        );
    end

    // floor toward minus infinity, add to base, saturate
    always_comb
    begin
        base_out = base_dly_reg[BASE_DLY-1];
        for (int k = 0; k < 3; k++)
        begin
            if (qovf[k])
                magq[k] = {1'b1, {C{1'b0}}};
            else
                magq[k] = {1'b0, quo[k]} + (C+1)'(qneg[k] & rnz[k]);
            qpos[k] = signed'({1'b0, magq[k]});
            qval[k] = qneg[k] ? -qpos[k] : qpos[k];
            sum[k]  = (C+3)'(signed'(base_out[k*C +: C])) + (C+3)'(qval[k]);
            if (base_out[BASE_W-1])
                near_next[k] = base_out[k*C +: C];
            else if ((sum[k][C+2:C-1] != '0) && (sum[k][C+2:C-1] != '1))
                near_next[k] = sum[k][C+2] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
            else
                near_next[k] = sum[k][C-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                near_reg[k] <= near_next[k];
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int k = 0; k < 3; k++)
            m_tdata[k*C +: C] = near_reg[k];
    end

    `CPT_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0], "accepted word lost at entry")
    `CPT_ASSERT_IMPL(a_stall_holds_input, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    `CPT_ASSERT_IMPL(a_zero_den_base, vld_reg[CLS_IDX] && (den_reg == '0), use_base_reg, "zero divisor not caught")

endmodule

`default_nettype wire

// ----- sv/cpt_mul.sv -----
// pipelined signed multiplier built from limb partial products
`default_nettype none

module cpt_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0]   p
);
    import cpt_pkg::*;

    localparam int L   = MUL_LIMB;
    localparam int NA  = (AW + L - 1) / L;
    localparam int NB  = (BW + L - 1) / L;
    localparam int AXW = NA * L;
    localparam int BXW = NB * L;
    localparam int PW  = AW + BW;
    localparam int TW  = AXW + BXW + 2;

    logic signed [AXW-1:0] ax;
    logic signed [BXW-1:0] bx;
    logic signed [L:0]     al [NA];
    logic signed [L:0]     bl [NB];

    logic signed [2*L+1:0] pp_reg [NA][NB];
    logic [TW-1:0]         row_reg [NA];
    logic [TW-1:0]         row_next [NA];
    logic [TW-1:0]         sum_next;
    logic [PW-1:0]         p_reg;

    // lower limbs are unsigned, the top limb carries the sign
    always_comb
    begin
        ax = AXW'(a);
        bx = BXW'(b);
        for (int i = 0; i < NA; i++)
        begin
            if (i == NA - 1)
                al[i] = {ax[i*L+L-1], ax[i*L +: L]};
            else
                al[i] = {1'b0, ax[i*L +: L]};
        end
        for (int j = 0; j < NB; j++)
        begin
            if (j == NB - 1)
                bl[j] = {bx[j*L+L-1], bx[j*L +: L]};
            else
                bl[j] = {1'b0, bx[j*L +: L]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
                row_next[i] = row_next[i] + (TW'(pp_reg[i][j]) << (L * j));
        end
        sum_next = '0;
        for (int i = 0; i < NA; i++)
            sum_next = sum_next + (row_reg[i] << (L * i));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                    pp_reg[i][j] <= al[i] * bl[j];
                row_reg[i] <= row_next[i];
            end
            p_reg <= sum_next[PW-1:0];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- sv/cpt_div.sv -----
// pipelined restoring divider, one quotient bit per stage, quotient overflow flagged
`default_nettype none

module cpt_div #(
    parameter int NW = 171,
    parameter int DW = 139,
    parameter int QW = 32
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic          neg_in,
    output logic [QW-1:0]      quo,
    output logic               rem_nz,
    output logic               neg,
    output logic               ovf
);
    import cpt_pkg::*;

    logic [NW-1:0] r_reg   [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [QW:0]   neg_reg;
    logic [QW:0]   ovf_reg;

    // quotient of 2^QW or more is only flagged
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= num;
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_in;
            ovf_reg[0] <= (num >> QW) >= NW'(den);
        end
    end

    for (genvar gj = 1; gj <= QW; gj++)
    begin : g_stage
        localparam int K = QW - gj;
        logic          take;
        logic [NW-1:0] r_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            take   = (r_reg[gj-1] >> K) >= NW'(d_reg[gj-1]);
            r_next = take ? r_reg[gj-1] - (NW'(d_reg[gj-1]) << K) : r_reg[gj-1];
            q_next = q_reg[gj-1];
            q_next[K] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[gj]   <= r_next;
                d_reg[gj]   <= d_reg[gj-1];
                q_reg[gj]   <= q_next;
                neg_reg[gj] <= neg_reg[gj-1];
                ovf_reg[gj] <= ovf_reg[gj-1];
            end
        end
    end

    assign quo    = q_reg[QW];
    assign rem_nz = |r_reg[QW];
    assign neg    = neg_reg[QW];
    assign ovf    = ovf_reg[QW];

endmodule

`default_nettype wire

// ----- bench/closest_point_on_triangle_core_tb.sv -----
// testbench for the closest point on triangle core: random and directed queries, scoreboarded
`timescale 1ns / 100ps

module closest_point_on_triangle_core_tb;

    typedef logic signed [319:0] wide_t;
    typedef logic signed [31:0] crd_t;
    typedef struct {
        crd_t v[12];
    } query_t;
    typedef struct packed {
        crd_t z;
        crd_t y;
        crd_t x;
    } point_t;

    class nearest_scoreboard;
        point_t pending[$];
        int     errors;
        int     matched;

        function wide_t dot3(wide_t u[3], wide_t w[3]);
            return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
        endfunction

        // floor division, divisor nonzero
        function wide_t floor_div(wide_t n, wide_t d);
            wide_t q;
            wide_t r;
            if (d < 0)
            begin
                n = -n;
                d = -d;
            end
            q = n / d;
            r = n % d;
            if (r != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        function wide_t clamp62(wide_t x);
            wide_t lim;
            lim = 1;
            lim = lim <<< 62;
            if (x >= lim)
                return lim;
            if (x < -lim)
                return -lim;
            return x;
        endfunction

        function crd_t sat32(wide_t x);
            if (x > 64'sd2147483647)
                return 32'sh7fffffff;
            if (x < -64'sd2147483648)
                return 32'sh80000000;
            return crd_t'(x);
        endfunction

        function point_t nearest_point(query_t q);
            wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
            wide_t r[3];
            wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, num, den;
            point_t res;
            for (int k = 0; k < 3; k++)
            begin
                p[k] = q.v[k];
                a[k] = q.v[3 + k];
                b[k] = q.v[6 + k];
                c[k] = q.v[9 + k];
                ab[k] = b[k] - a[k];
                ac[k] = c[k] - a[k];
                bc[k] = c[k] - b[k];
                ap[k] = p[k] - a[k];
                bp[k] = p[k] - b[k];
                cp[k] = p[k] - c[k];
                r[k] = a[k];
            end
            d1 = dot3(ab, ap);
            d2 = dot3(ac, ap);
            d3 = dot3(ab, bp);
            d4 = dot3(ac, bp);
            d5 = dot3(ab, cp);
            d6 = dot3(ac, cp);
            vc = d1 * d4 - d3 * d2;
            vb = d5 * d2 - d1 * d6;
            va = d3 * d6 - d5 * d4;
            if (d1 <= 0 && d2 <= 0)
                ;
            else if (d3 >= 0 && d3 - d4 >= 0)
                r = b;
            else if (vc <= 0 && d1 >= 0 && d3 <= 0)
            begin
                den = d1 - d3;
                if (den != 0)
                    for (int k = 0; k < 3; k++)
                        r[k] = a[k] + clamp62(floor_div(d1 * ab[k], den));
            end
            else if (d6 >= 0 && d6 - d5 >= 0)
                r = c;
            else if (vb <= 0 && d2 >= 0 && d6 <= 0)
            begin
                den = d2 - d6;
                if (den != 0)
                    for (int k = 0; k < 3; k++)
                        r[k] = a[k] + clamp62(floor_div(d2 * ac[k], den));
            end
            else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
            begin
                num = d4 - d3;
                den = num + (d5 - d6);
                r = b;
                if (den != 0)
                    for (int k = 0; k < 3; k++)
                        r[k] = b[k] + clamp62(floor_div(num * bc[k], den));
            end
            else
            begin
                den = va + vb + vc;
                if (den != 0)
                    for (int k = 0; k < 3; k++)
                        r[k] = a[k] + clamp62(floor_div(vb * ab[k] + vc * ac[k], den));
            end
            res.x = sat32(r[0]);
            res.y = sat32(r[1]);
            res.z = sat32(r[2]);
            return res;
        endfunction

        function void note_query(query_t q);
            pending.insert(pending.size(), nearest_point(q));
        endfunction

        function void check_result(logic [95:0] word);
            point_t got;
            point_t want;
            got = word;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, word);
                errors++;
                return;
            end
            want = pending[0];
            pending.delete(0);
            matched++;
            if (got.x !== want.x)
            begin
                $display("%0t: near_x expected %0d got %0d", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $display("%0t: near_y expected %0d got %0d", $time, want.y, got.y);
                errors++;
            end
            if (got.z !== want.z)
            begin
                $display("%0t: near_z expected %0d got %0d", $time, want.z, got.z);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;

    nearest_scoreboard sb;
    bit  gaps_on;
    int  sent;
    int  idle_cycles;

    closest_point_on_triangle_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_query(query_t q);
        int gap;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        for (int k = 0; k < 12; k++)
            s_tdata[k * 32 +: 32] = q.v[k];
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_query(q);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_tri(crd_t px, crd_t py, crd_t pz, crd_t ax, crd_t ay, crd_t az,
                            crd_t bx, crd_t by, crd_t bz, crd_t cx, crd_t cy, crd_t cz);
        query_t q;
        q.v = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
        send_query(q);
    endtask

    function automatic crd_t rand_near(int span);
        return crd_t'($urandom_range(0, 2 * span)) - crd_t'(span);
    endfunction

    // mostly small triangles with a nearby point, sometimes full range coordinates
    task automatic send_random();
        query_t q;
        int mode;
        int span;
        crd_t off;
        mode = $urandom_range(0, 9);
        span = (mode < 4) ? 1 << 12 : (mode < 7) ? 1 << 20 : 1 << 28;
        off = crd_t'($urandom);
        for (int k = 0; k < 12; k++)
            q.v[k] = (mode == 9) ? crd_t'($urandom) : (off >>> 3) + rand_near(span);
        if (mode == 8)
        begin
            // degenerate: repeated or collinear vertices
            for (int k = 0; k < 3; k++)
                q.v[6 + k] = q.v[3 + k];
            if ($urandom_range(0, 1))
                for (int k = 0; k < 3; k++)
                    q.v[9 + k] = q.v[3 + k] + (q.v[3 + k] >>> 4);
        end
        send_query(q);
    endtask

    task automatic drain(int extra);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // result side, random stall before each word while gaps_on is set
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 3000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        crd_t u;
        sb = new();
        gaps_on = 1'b1;
        sent = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        u = 32'sd10 <<< 16;
        // each region of a right triangle in the xy plane
        send_tri(-65536, -65536, 0, 0, 0, 0, u, 0, 0, 0, u, 0);
        send_tri(u + 65536, -65536, 0, 0, 0, 0, u, 0, 0, 0, u, 0);
        send_tri(-65536, u + 65536, 0, 0, 0, 0, u, 0, 0, 0, u, 0);
        send_tri(u / 2, -3 * 65536, 0, 0, 0, 0, u, 0, 0, 0, u, 0);
        send_tri(-3 * 65536, u / 3, 0, 0, 0, 0, u, 0, 0, 0, u, 0);
        send_tri(u * 7 / 10, u * 6 / 10, 4, 0, 0, 0, u, 0, 0, 0, u, 0);
        send_tri(u / 5, u / 7, 5 * 65536, 0, 0, 0, u, 0, 0, 0, u, 0);
        send_tri(u / 3, u / 3, -7, 0, 0, 0, u, 0, 0, 0, u, 0);
        // point on a vertex, degenerate triangles
        send_tri(1, 2, 3, 1, 2, 3, 5, 9, 1, -4, 6, 2);
        send_tri(7, 8, 9, 1, 1, 1, 1, 1, 1, 1, 1, 1);
        send_tri(7, -8, 9, 0, 0, 0, 3, 3, 3, 6, 6, 6);
        send_tri(2, 9, 2, 0, 0, 0, 0, 0, 0, 6, 6, 6);
        // extremes of the coordinate range
        send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tri('1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1,
                 '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1);
        send_tri(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 32'sh80000000, -1);
        send_tri(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        send_tri(0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff,
                 32'sh80000000, 0, 0, 32'sh7fffffff, 0);
        send_tri(-1, -1, -1, 32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 0,
                 32'sh80000000, 0, 32'sh7fffffff, 0);

        // wait out the pipeline with nothing in flight
        s_tvalid = 1'b0;
        drain(60);

        for (int i = 0; i < 1100; i++)
        begin
            // alternate stretches with and without idling
            if (i % 150 == 0)
                gaps_on = (i / 150) % 3 != 1;
            send_random();
        end
        s_tvalid = 1'b0;
        drain(60);

        $display("sent %0d queries, checked %0d nearest points, all regions and extremes",
                 sent, sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cpt_pkg.sv
sv/cpt_mul.sv
sv/cpt_div.sv
sv/closest_point_on_triangle_core.sv
bench/closest_point_on_triangle_core_tb.sv
